// ===== hdl/lms_pkg.sv =====
// Shared constants, message codes and types for the mutual exclusion site.
package lms_pkg;

  localparam int MAX_SITES  = 16;
  localparam int SITE_BITS  = $clog2(MAX_SITES);
  localparam int CNT_BITS   = SITE_BITS + 1;
  localparam int CLOCK_BITS = 32;

  // Message kinds
  localparam logic [1:0] KIND_RELEASE = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_GRANT   = 2'd2;

  // Local actions
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_EVENT   = 2'd1;
  localparam logic [1:0] ACT_REQUEST = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SITE_ID    = 2'd0;
  localparam logic [1:0] CFG_SITE_COUNT = 2'd1;
  localparam logic [1:0] CFG_HOLD_TICKS = 2'd2;

  typedef struct packed {
    logic [CLOCK_BITS-1:0] max_inc;  // max(a, b) + 1, wrapping
    logic                  a_lt_b;   // a < b, unsigned
  } alu_res_t;

endpackage

// ===== hdl/lms_alu.sv =====
// Shared clock unit: one unsigned compare feeding a max-plus-one incrementer.
module lms_alu (
  input  logic [lms_pkg::CLOCK_BITS-1:0] a,
  input  logic [lms_pkg::CLOCK_BITS-1:0] b,
  output lms_pkg::alu_res_t              res
);

  logic                          lt;
  logic [lms_pkg::CLOCK_BITS-1:0] larger;

  assign lt          = a < b;
  assign larger      = lt ? b : a;
  assign res.a_lt_b  = lt;
  assign res.max_inc = larger + lms_pkg::CLOCK_BITS'(1);

endmodule

// ===== hdl/lamport_mutex_site.sv =====
// Top level of one site of a Lamport distributed mutual exclusion scheme.
//
// One input item on the s_axis channel is one tick: a local action and an
// optional received message. For every tick the m_axis channel carries one
// to three result items, in the order request, grant, release; a tick that
// sends nothing yields one quiet item with send_valid low. tlast marks the
// final item of the tick, and every item of a tick reports the logical clock
// and critical-section flag as they stand at the end of that tick.
// Config writes (cfg_wr_en/cfg_index/cfg_wdata) are taken at any edge and
// must only happen while the site is idle.
// Timing: s_axis_tready is high only in the idle state. A tick walks through
// local action, message, a scan of all site entries, entry and hold steps,
// all on one shared compare/increment unit. The scan reads the stamp memory
// one entry per cycle (registered read) and is skipped when the site cannot
// enter anyway. If the receiver stalls, the output register holds the item
// and the sequencer waits; the next tick can be accepted while the final
// item of the previous one is still waiting. Reset clears the clock, all
// pending and grant flags, the hold state and the config to its defaults.
module lamport_mutex_site (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_wdata,
  // Tick input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] msg_valid, [4:1] msg_sender, [36:5] msg_clock, [40:37] msg_target,
  // [41] msg_broadcast, [47:42] zero
  input  logic [47:0] s_axis_tdata,
  // [1:0] local_action, [3:2] msg_kind
  input  logic [3:0]  s_axis_tuser,
  // Result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] send_valid, [32:1] send_clock, [36:33] send_target, [37] send_broadcast,
  // [69:38] clock_now, [70] in_critical, [71] zero
  output logic [71:0] m_axis_tdata,
  // [1:0] send_kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int SB = lms_pkg::SITE_BITS;
  localparam int CB = lms_pkg::CNT_BITS;
  localparam int KB = lms_pkg::CLOCK_BITS;
  localparam int NS = lms_pkg::MAX_SITES;

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOCAL = 3'd1;
  localparam logic [2:0] ST_MSG   = 3'd2;
  localparam logic [2:0] ST_MSG2  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_ENTER = 3'd5;
  localparam logic [2:0] ST_HOLD  = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  // Config
  logic [SB-1:0] site_id;
  logic [CB-1:0] site_count;
  logic [3:0]    hold_ticks;

  // Site state
  logic [KB-1:0] logical_clock;
  logic [NS-1:0] request_pending;
  logic [NS-1:0] grant_seen;
  logic          holding;
  logic [3:0]    hold_count;
  logic [KB-1:0] stamp_mem [NS];
  logic [KB-1:0] rd_data;

  logic [2:0]    state;

  // Latched tick
  logic [1:0]    act;
  logic          mv;
  logic [1:0]    kind;
  logic [SB-1:0] sender;
  logic [KB-1:0] mclk;
  logic [SB-1:0] target;
  logic          bc;

  // Scan
  logic [CB-1:0] scan_idx;
  logic          cmp_valid;
  logic [SB-1:0] cmp_idx;
  logic          found;
  logic [KB-1:0] best;
  logic [SB-1:0] pos;

  // Pending result items of this tick
  logic          emit_req, emit_gnt, emit_rel;
  logic [KB-1:0] req_clk, gnt_clk, rel_clk;
  logic [SB-1:0] gnt_tgt;

  // Output register
  logic          out_sv;
  logic [1:0]    out_kind;
  logic [KB-1:0] out_clk;
  logic [SB-1:0] out_tgt;
  logic          out_bc;
  logic [KB-1:0] out_now;
  logic          out_crit;
  logic          out_last;

  // Shared unit
  logic [KB-1:0]     alu_a, alu_b;
  lms_pkg::alu_res_t alu;

  lms_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu)
  );

  // Effective site count: 0 acts as 1, saturates at the site limit
  logic [CB-1:0] n_eff;
  logic          self_ok, sender_ok;
  logic [NS-1:0] site_mask;
  logic          all_granted;
  logic          scan_skip;
  logic          out_free;

  always_comb begin
    if (site_count == '0) begin
      n_eff = CB'(1);
    end else if (site_count > CB'(NS)) begin
      n_eff = CB'(NS);
    end else begin
      n_eff = site_count;
    end
  end

  assign self_ok   = {1'b0, site_id} < n_eff;
  assign sender_ok = {1'b0, sender} < n_eff;

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      site_mask[i] = CB'(i) < n_eff;
    end
  end

  assign all_granted = &(grant_seen | ~site_mask);
  // The site cannot enter: no need to walk the entries
  assign scan_skip   = holding || !self_ok || !request_pending[site_id] || !all_granted;
  assign out_free    = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    alu_a = logical_clock;
    alu_b = '0;
    case (state)
      ST_MSG:  alu_b = mclk;
      ST_SCAN: begin
        alu_a = rd_data;
        alu_b = best;
      end
      default: alu_b = '0;
    endcase
  end

  // Stamp memory write: own request in the local step, received request in
  // the message step
  logic          mem_we;
  logic [SB-1:0] mem_waddr;
  logic [KB-1:0] mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = site_id;
    mem_wdata = alu.max_inc;
    if (state == ST_LOCAL && act == lms_pkg::ACT_REQUEST &&
        !(self_ok && request_pending[site_id]) && self_ok) begin
      mem_we = 1'b1;
    end else if (state == ST_MSG && mv && sender_ok && kind == lms_pkg::KIND_REQUEST) begin
      mem_we    = 1'b1;
      mem_waddr = sender;
      mem_wdata = mclk;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stamp_mem[mem_waddr] <= mem_wdata;
    end
    if (state == ST_SCAN) begin
      rd_data <= stamp_mem[scan_idx[SB-1:0]];
    end
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      site_id    <= '0;
      site_count <= CB'(2);
      hold_ticks <= 4'd5;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lms_pkg::CFG_SITE_ID:    site_id    <= cfg_wdata[SB-1:0];
        lms_pkg::CFG_SITE_COUNT: site_count <= cfg_wdata[CB-1:0];
        lms_pkg::CFG_HOLD_TICKS: hold_ticks <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      logical_clock   <= '0;
      request_pending <= '0;
      grant_seen      <= '0;
      holding         <= 1'b0;
      hold_count      <= '0;
      emit_req        <= 1'b0;
      emit_gnt        <= 1'b0;
      emit_rel        <= 1'b0;
      cmp_valid       <= 1'b0;
      found           <= 1'b0;
      scan_idx        <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            act    <= s_axis_tuser[1:0];
            kind   <= s_axis_tuser[3:2];
            mv     <= s_axis_tdata[0];
            sender <= s_axis_tdata[4:1];
            mclk   <= s_axis_tdata[36:5];
            target <= s_axis_tdata[40:37];
            bc     <= s_axis_tdata[41];
            state  <= ST_LOCAL;
          end
        end

        ST_LOCAL: begin
          scan_idx  <= '0;
          cmp_valid <= 1'b0;
          found     <= 1'b0;
          if (act == lms_pkg::ACT_EVENT) begin
            if (!holding) begin
              logical_clock <= alu.max_inc;
            end
          end else if (act == lms_pkg::ACT_REQUEST) begin
            if (!(self_ok && request_pending[site_id])) begin
              logical_clock <= alu.max_inc;
              emit_req      <= 1'b1;
              req_clk       <= alu.max_inc;
              if (self_ok) begin
                request_pending[site_id] <= 1'b1;
                grant_seen[site_id]      <= 1'b1;
              end
            end
          end
          state <= ST_MSG;
        end

        ST_MSG: begin
          state <= ST_SCAN;
          if (mv && sender_ok) begin
            case (kind)
              lms_pkg::KIND_RELEASE: begin
                logical_clock           <= alu.max_inc;
                request_pending[sender] <= 1'b0;
              end
              lms_pkg::KIND_REQUEST: begin
                logical_clock           <= alu.max_inc;
                request_pending[sender] <= 1'b1;
                state                   <= ST_MSG2;
              end
              lms_pkg::KIND_GRANT: begin
                if (!bc && target == site_id) begin
                  logical_clock      <= alu.max_inc;
                  grant_seen[sender] <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end

        ST_MSG2: begin
          // Grant answer to a received request
          logical_clock <= alu.max_inc;
          emit_gnt      <= 1'b1;
          gnt_clk       <= alu.max_inc;
          gnt_tgt       <= sender;
          state         <= ST_SCAN;
        end

        ST_SCAN: begin
          if (scan_skip) begin
            state <= ST_HOLD;
          end else begin
            // Compare the entry read last cycle, ties keep the lower index
            if (cmp_valid && request_pending[cmp_idx] && (!found || alu.a_lt_b)) begin
              found <= 1'b1;
              best  <= rd_data;
              pos   <= cmp_idx;
            end
            if (scan_idx < n_eff) begin
              cmp_idx   <= scan_idx[SB-1:0];
              cmp_valid <= 1'b1;
              scan_idx  <= scan_idx + CB'(1);
            end else begin
              cmp_valid <= 1'b0;
              if (!cmp_valid) begin
                state <= (found && pos == site_id) ? ST_ENTER : ST_HOLD;
              end
            end
          end
        end

        ST_ENTER: begin
          logical_clock <= alu.max_inc;
          holding       <= 1'b1;
          state         <= ST_HOLD;
        end

        ST_HOLD: begin
          if (holding) begin
            if (hold_count >= hold_ticks) begin
              logical_clock <= alu.max_inc;
              emit_rel      <= 1'b1;
              rel_clk       <= alu.max_inc;
              if (self_ok) begin
                request_pending[site_id] <= 1'b0;
              end
              grant_seen <= '0;
              holding    <= 1'b0;
              hold_count <= '0;
            end else begin
              hold_count <= hold_count + 4'd1;
            end
          end
          state <= ST_OUT;
        end

        ST_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            out_now       <= logical_clock;
            out_crit      <= holding;
            out_sv        <= 1'b1;
            out_tgt       <= '0;
            out_bc        <= 1'b1;
            if (emit_req) begin
              emit_req <= 1'b0;
              out_kind <= lms_pkg::KIND_REQUEST;
              out_clk  <= req_clk;
              out_last <= !(emit_gnt || emit_rel);
              if (!(emit_gnt || emit_rel)) begin
                state <= ST_IDLE;
              end
            end else if (emit_gnt) begin
              emit_gnt <= 1'b0;
              out_kind <= lms_pkg::KIND_GRANT;
              out_clk  <= gnt_clk;
              out_tgt  <= gnt_tgt;
              out_bc   <= 1'b0;
              out_last <= !emit_rel;
              if (!emit_rel) begin
                state <= ST_IDLE;
              end
            end else if (emit_rel) begin
              emit_rel <= 1'b0;
              out_kind <= lms_pkg::KIND_RELEASE;
              out_clk  <= rel_clk;
              out_last <= 1'b1;
              state    <= ST_IDLE;
            end else begin
              // Quiet tick
              out_sv   <= 1'b0;
              out_kind <= lms_pkg::KIND_RELEASE;
              out_clk  <= '0;
              out_bc   <= 1'b0;
              out_last <= 1'b1;
              state    <= ST_IDLE;
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {1'b0, out_crit, out_now, out_bc, out_tgt, out_clk, out_sv};
  assign m_axis_tuser = out_kind;
  assign m_axis_tlast = out_last;

  // Hold counter only runs while the section is held
  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !holding |-> hold_count == '0)
    else $error("hold counter nonzero outside the critical section");

  // Every queued result item is moved to the output register before the next tick is taken
  a_drained: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !(emit_req || emit_gnt || emit_rel))
    else $error("result items left over at end of tick");

  // Leaving the section clears every collected grant
  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    $fell(holding) |-> grant_seen == '0)
    else $error("grants kept across a release");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for one site of the Lamport mutual exclusion block.
`timescale 1ns / 100ps

module tb_top;
  import lms_pkg::*;

  // Codes the package leaves unnamed: both are ignored by the block
  localparam logic [1:0] ACT_RESERVED  = 2'd3;
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  localparam int NUM_PHASES   = 10;
  localparam int PHASE_TICKS  = 39;
  localparam int DRAIN_CYCLES = 30;
  localparam int REPORT_CAP   = 200;  // keep a broken run's log readable

  // One tick as the sender sees it
  typedef struct packed {
    logic [1:0]  action;
    logic        mv;
    logic [1:0]  kind;
    logic [3:0]  sender;
    logic [31:0] mclk;
    logic [3:0]  target;
    logic        bc;
  } tick_t;

  // One result item as it leaves the block
  typedef struct packed {
    logic        sv;
    logic [1:0]  kind;
    logic [31:0] sclk;
    logic [3:0]  tgt;
    logic        bc;
    logic [31:0] now;
    logic        crit;
    logic        last;
  } result_t;

  // Directed row: expected item typed in only where it is obvious
  typedef struct packed {
    tick_t   t;
    logic    typed;
    result_t want;
  } dir_row_t;

  typedef struct packed {
    logic [3:0] id;
    logic [4:0] count;
    logic [3:0] hold;
  } site_cfg_t;

  // ---------------------------------------------------------------------------
  // DUT signals; the inputs are all known from time zero
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = CFG_SITE_ID;
  logic [4:0]  cfg_wdata = 5'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = 48'd0;  // [0] mv, [4:1] sender, [36:5] clock, [40:37] target,
                                      // [41] broadcast, [47:42] zero
  logic [3:0]  s_axis_tuser = 4'd0;   // [1:0] local action, [3:2] message kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;          // [0] send_valid, [32:1] send_clock, [36:33] target,
                                      // [37] broadcast, [69:38] clock_now, [70] in_critical
  logic [1:0]  m_axis_tuser;          // [1:0] send_kind
  logic        m_axis_tlast;

  lamport_mutex_site uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Site model: our own copy of clock, request queue, grants and hold state
  // ---------------------------------------------------------------------------
  logic [3:0]  cfg_id    = 4'd0;
  logic [4:0]  cfg_count = 5'd2;
  logic [3:0]  cfg_hold  = 4'd5;

  logic [31:0] lclock = 32'd0;
  logic [31:0] req_stamp [MAX_SITES];
  bit          req_pend  [MAX_SITES];
  bit          grant_in  [MAX_SITES];
  bit          in_cs     = 1'b0;
  logic [3:0]  hold_cnt  = 4'd0;

  result_t     tick_out [3];   // items caused by the latest tick
  result_t     due_items [$];  // items the block still owes us

  int fail_count    = 0;
  int ticks_sent    = 0;
  int phase_ticks   = 0;
  int items_checked = 0;
  int cs_entries    = 0;
  int phases_run    = 0;

  bit src_idle = 1'b1;   // sender inserts gaps
  bit stall_en = 1'b0;   // receiver drops tready
  int sink_left = 0;

  // count 0 behaves as one site, anything above the array saturates
  function automatic int eff_sites();
    if (cfg_count == 5'd0) return 1;
    if (int'(cfg_count) > MAX_SITES) return MAX_SITES;
    return int'(cfg_count);
  endfunction

  // Lamport receive rule: max(local, stamp) + 1, wrapping
  function automatic void bump(input logic [31:0] stamp);
    lclock = ((lclock > stamp) ? lclock : stamp) + 32'd1;
  endfunction

  // Outgoing message stamped with the clock as it stands now
  function automatic result_t msg_res(input logic [1:0] kind, input logic [3:0] tgt,
                                      input logic bc);
    return '{1'b1, kind, lclock, tgt, bc, 32'd0, 1'b0, 1'b0};
  endfunction

  // Advance the model by one tick; fills tick_out and returns the item count
  function automatic int predict_site_tick(input tick_t t);
    int n, k, pos, i;
    bit self_ok, all_in;
    logic [31:0] best;
    n = eff_sites();
    k = 0;
    self_ok = int'(cfg_id) < n;

    // local action first
    if (t.action == ACT_EVENT) begin
      if (!in_cs) lclock = lclock + 32'd1;
    end else if (t.action == ACT_REQUEST) begin
      if (!(self_ok && req_pend[cfg_id])) begin
        lclock = lclock + 32'd1;
        if (self_ok) begin
          req_stamp[cfg_id] = lclock;
          req_pend[cfg_id]  = 1'b1;
          grant_in[cfg_id]  = 1'b1;
        end
        tick_out[k] = msg_res(KIND_REQUEST, 4'd0, 1'b1);
        k++;
      end
    end

    // then the received message; senders outside the group are dropped
    if (t.mv && int'(t.sender) < n) begin
      case (t.kind)
        KIND_RELEASE: begin
          bump(t.mclk);
          req_pend[t.sender] = 1'b0;
        end
        KIND_REQUEST: begin
          bump(t.mclk);
          req_stamp[t.sender] = t.mclk;
          req_pend[t.sender]  = 1'b1;
          lclock = lclock + 32'd1;
          tick_out[k] = msg_res(KIND_GRANT, t.sender, 1'b0);
          k++;
        end
        KIND_GRANT: begin
          // only a unicast grant addressed to us counts
          if (!t.bc && t.target == cfg_id) begin
            bump(t.mclk);
            grant_in[t.sender] = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // entry: own request oldest (ties to lowest index) and all grants in
    if (!in_cs && self_ok) begin
      pos = -1;
      best = 32'd0;
      all_in = 1'b1;
      for (i = 0; i < n; i++) begin
        if (req_pend[i] && (pos < 0 || req_stamp[i] < best)) begin
          pos = i;
          best = req_stamp[i];
        end
        if (!grant_in[i]) all_in = 1'b0;
      end
      if (pos == int'(cfg_id) && all_in) begin
        lclock = lclock + 32'd1;
        in_cs = 1'b1;
        cs_entries++;
      end
    end

    // hold: entry tick is the first held tick
    if (in_cs) begin
      if (hold_cnt >= cfg_hold) begin
        lclock = lclock + 32'd1;
        tick_out[k] = msg_res(KIND_RELEASE, 4'd0, 1'b1);
        k++;
        if (self_ok) req_pend[cfg_id] = 1'b0;
        for (i = 0; i < MAX_SITES; i++) grant_in[i] = 1'b0;
        in_cs = 1'b0;
        hold_cnt = 4'd0;
      end else begin
        hold_cnt = hold_cnt + 4'd1;
      end
    end

    // nothing sent: one quiet item with zeroed message fields
    if (k == 0) begin
      tick_out[0] = '0;
      k = 1;
    end
    for (i = 0; i < k; i++) begin
      tick_out[i].now  = lclock;
      tick_out[i].crit = in_cs;
      tick_out[i].last = (i == k - 1);
    end
    return k;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic tick_t mk_tick(input logic [1:0] action, input logic mv,
                                    input logic [1:0] kind, input logic [3:0] sender,
                                    input logic [31:0] mclk, input logic [3:0] target,
                                    input logic bc);
    return '{action, mv, kind, sender, mclk, target, bc};
  endfunction

  function automatic result_t quiet_res(input logic [31:0] now, input logic crit);
    return '{1'b0, 2'd0, 32'd0, 4'd0, 1'b0, now, crit, 1'b1};
  endfunction

  function automatic result_t mk_res(input logic [1:0] kind, input logic [31:0] sclk,
                                     input logic [3:0] tgt, input logic bc,
                                     input logic [31:0] now, input logic crit);
    return '{1'b1, kind, sclk, tgt, bc, now, crit, 1'b1};
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) return $urandom_range(0, 2);
    if (r < 19) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // stamps near our clock exercise both sides of max(); the rest hit wrap and all bits
  function automatic logic [31:0] pick_stamp();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return lclock + 32'($urandom_range(0, 6)) - 32'd3;
      4:          return $urandom();
      5:          return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
      default:    return 32'($urandom_range(0, 3));
    endcase
  endfunction

  // unconstrained tick, senders mostly inside the group
  function automatic tick_t rand_tick();
    tick_t t;
    t.action = 2'($urandom_range(0, 3));
    t.mv     = 1'($urandom_range(0, 1));
    t.kind   = 2'($urandom_range(0, 3));
    t.sender = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, eff_sites() - 1));
    t.mclk   = pick_stamp();
    t.target = ($urandom_range(0, 1) == 0) ? cfg_id : 4'($urandom_range(0, 15));
    t.bc     = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // Offer one tick, predict at the accepting edge, then maybe idle.
  // With no gap tvalid simply stays high for the next call.
  task automatic send_tick(input tick_t t, input logic typed, input result_t want);
    int cnt, gap, i;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, t.bc, t.target, t.mclk, t.sender, t.mv};
    s_axis_tuser  <= {t.kind, t.action};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    cnt = predict_site_tick(t);
    if (typed) begin
      due_items.push_back(want);
    end else begin
      for (i = 0; i < cnt; i++) due_items.push_back(tick_out[i]);
    end
    ticks_sent++;
    phase_ticks++;
    gap = src_idle ? draw_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Block idle: every owed item out, then a tick's worth of cycles
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (due_items.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Three back-to-back writes; wr_en only drops after the last one
  task automatic write_config(input site_cfg_t c);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SITE_ID;
    cfg_wdata <= {1'b0, c.id};
    @(posedge clk);
    cfg_id = c.id;
    cfg_index <= CFG_SITE_COUNT;
    cfg_wdata <= c.count;
    @(posedge clk);
    cfg_count = c.count;
    cfg_index <= CFG_HOLD_TICKS;
    cfg_wdata <= {1'b0, c.hold};
    @(posedge clk);
    cfg_hold = c.hold;
    cfg_wr_en <= 1'b0;
  endtask

  // One well-formed round: request, grants from every peer (shuffled) mixed
  // with peer requests and noise, releases for any peer still queued, then
  // enough ticks to see the hold run out.
  task automatic run_session();
    int n, cnt, j, k, tmp;
    int order [MAX_SITES];
    tick_t t;
    n = eff_sites();
    t = rand_tick();
    t.action = ACT_REQUEST;
    if ($urandom_range(0, 4) != 0) t.mv = 1'b0;
    send_tick(t, 1'b0, '0);

    cnt = 0;
    for (k = 0; k < n; k++) begin
      if (k != int'(cfg_id)) begin
        order[cnt] = k;
        cnt++;
      end
    end
    for (k = cnt - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end

    for (k = 0; k < cnt; k++) begin
      if ($urandom_range(0, 3) == 0)
        send_tick(mk_tick(ACT_NONE, 1'b1, KIND_REQUEST, 4'($urandom_range(0, n - 1)),
                          pick_stamp(), 4'd0, 1'b1), 1'b0, '0);
      if ($urandom_range(0, 7) == 0)
        send_tick(rand_tick(), 1'b0, '0);
      send_tick(mk_tick(($urandom_range(0, 3) == 0) ? ACT_EVENT : ACT_NONE, 1'b1,
                        KIND_GRANT, 4'(order[k]), pick_stamp(), cfg_id, 1'b0),
                1'b0, '0);
    end

    for (k = 0; k < n; k++) begin
      if (k != int'(cfg_id) && req_pend[k])
        send_tick(mk_tick(ACT_NONE, 1'b1, KIND_RELEASE, 4'(k), pick_stamp(), 4'd0, 1'b1),
                  1'b0, '0);
    end

    for (k = 0; k < 18 && (in_cs || (int'(cfg_id) < n && req_pend[cfg_id])); k++)
      send_tick(mk_tick(($urandom_range(0, 2) == 0) ? ACT_EVENT : ACT_NONE, 1'b0,
                        KIND_RELEASE, 4'd0, 32'd0, 4'd0, 1'b0), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random tready stalls, one toggle per step
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!stall_en) begin
      m_axis_tready <= 1'b1;
    end else if (sink_left != 0) begin
      sink_left = sink_left - 1;
    end else begin
      m_axis_tready <= !m_axis_tready;
      sink_left = draw_gap();
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      if (fail_count < REPORT_CAP)
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Result checker: each accepted item against the oldest owed one
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[0], m_axis_tuser, m_axis_tdata[32:1], m_axis_tdata[36:33],
              m_axis_tdata[37], m_axis_tdata[69:38], m_axis_tdata[70], m_axis_tlast};
      if (due_items.size() == 0) begin
        $error("result item with none due: send_kind %0d clock_now %0h",
               got.kind, got.now);
        fail_count++;
      end else begin
        want = due_items.pop_front();
        items_checked++;
        check_field("send_valid",     32'(want.sv),   32'(got.sv));
        check_field("send_kind",      32'(want.kind), 32'(got.kind));
        check_field("send_clock",     want.sclk,      got.sclk);
        check_field("send_target",    32'(want.tgt),  32'(got.tgt));
        check_field("send_broadcast", 32'(want.bc),   32'(got.bc));
        check_field("clock_now",      want.now,       got.now);
        check_field("in_critical",    32'(want.crit), 32'(got.crit));
        check_field("last_of_tick",   32'(want.last), 32'(got.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t  dir_rows [$];
    site_cfg_t phase_cfg [NUM_PHASES];
    int r, ph;

    foreach (req_stamp[i]) begin
      req_stamp[i] = 32'd0;
      req_pend[i]  = 1'b0;
      grant_in[i]  = 1'b0;
    end

    // Directed walk at reset defaults: site 0 of 2, hold 5.
    // Early rows are simple enough to type the answer in.
    dir_rows.push_back('{mk_tick(ACT_NONE, 1'b0, KIND_RELEASE, 4'd0, 32'd0, 4'd0, 1'b0),
                         1'b1, quiet_res(32'd0, 1'b0)});
    // reserved action and reserved kind: no effect at all
    dir_rows.push_back('{mk_tick(ACT_RESERVED, 1'b1, KIND_RESERVED, 4'd1, 32'hFFFF_FFFF,
                                 4'd0, 1'b0), 1'b1, quiet_res(32'd0, 1'b0)});
    dir_rows.push_back('{mk_tick(ACT_EVENT, 1'b0, KIND_RELEASE, 4'd0, 32'd0, 4'd0, 1'b0),
                         1'b1, quiet_res(32'd1, 1'b0)});
    // broadcast grant, then grant addressed elsewhere: both dropped
    dir_rows.push_back('{mk_tick(ACT_NONE, 1'b1, KIND_GRANT, 4'd1, 32'hFFFF_FFFF, 4'd0, 1'b1),
                         1'b1, quiet_res(32'd1, 1'b0)});
    dir_rows.push_back('{mk_tick(ACT_NONE, 1'b1, KIND_GRANT, 4'd1, 32'hFFFF_FFFF, 4'd5, 1'b0),
                         1'b1, quiet_res(32'd1, 1'b0)});
    // sender beyond the group
    dir_rows.push_back('{mk_tick(ACT_NONE, 1'b1, KIND_RELEASE, 4'd15, 32'hFFFF_FFFF, 4'd15,
                                 1'b1), 1'b1, quiet_res(32'd1, 1'b0)});
    // own request, then a repeat while it is still queued
    dir_rows.push_back('{mk_tick(ACT_REQUEST, 1'b0, KIND_RELEASE, 4'd0, 32'd0, 4'd0, 1'b0),
                         1'b1, mk_res(KIND_REQUEST, 32'd2, 4'd0, 1'b1, 32'd2, 1'b0)});
    dir_rows.push_back('{mk_tick(ACT_REQUEST, 1'b0, KIND_RELEASE, 4'd0, 32'd0, 4'd0, 1'b0),
                         1'b1, quiet_res(32'd2, 1'b0)});
    // older peer request gets a grant and blocks us
    dir_rows.push_back('{mk_tick(ACT_NONE, 1'b1, KIND_REQUEST, 4'd1, 32'd1, 4'd0, 1'b0),
                         1'b1, mk_res(KIND_GRANT, 32'd4, 4'd1, 1'b0, 32'd4, 1'b0)});
    dir_rows.push_back('{mk_tick(ACT_NONE, 1'b1, KIND_GRANT, 4'd1, 32'd0, 4'd0, 1'b0),
                         1'b1, quiet_res(32'd5, 1'b0)});
    // peer releases: we enter on the same tick
    dir_rows.push_back('{mk_tick(ACT_NONE, 1'b1, KIND_RELEASE, 4'd1, 32'd10, 4'd0, 1'b1),
                         1'b1, quiet_res(32'd12, 1'b1)});
    // local event while holding is ignored
    dir_rows.push_back('{mk_tick(ACT_EVENT, 1'b0, KIND_RELEASE, 4'd0, 32'd0, 4'd0, 1'b0),
                         1'b1, quiet_res(32'd12, 1'b1)});
    for (r = 0; r < 3; r++)
      dir_rows.push_back('{mk_tick(ACT_NONE, 1'b0, KIND_RELEASE, 4'd0, 32'd0, 4'd0, 1'b0),
                           1'b1, quiet_res(32'd12, 1'b1)});
    // sixth held tick with hold 5: release goes out
    dir_rows.push_back('{mk_tick(ACT_NONE, 1'b0, KIND_RELEASE, 4'd0, 32'd0, 4'd0, 1'b0),
                         1'b1, mk_res(KIND_RELEASE, 32'd13, 4'd0, 1'b1, 32'd13, 1'b0)});
    // from here on the model supplies the answer
    // request and grant in one tick
    dir_rows.push_back('{mk_tick(ACT_REQUEST, 1'b1, KIND_REQUEST, 4'd1, 32'd20, 4'd0, 1'b1),
                         1'b0, '0});
    // grant stamped at the top of the range: clock wraps, then we enter
    dir_rows.push_back('{mk_tick(ACT_NONE, 1'b1, KIND_GRANT, 4'd1, 32'hFFFF_FFFF, 4'd0, 1'b0),
                         1'b0, '0});
    // request carrying our own index while holding
    dir_rows.push_back('{mk_tick(ACT_NONE, 1'b1, KIND_REQUEST, 4'd0, 32'd0, 4'd15, 1'b0),
                         1'b0, '0});
    // message fields set but msg_valid low
    dir_rows.push_back('{mk_tick(ACT_EVENT, 1'b0, KIND_RELEASE, 4'd1, 32'hFFFF_FFFF, 4'd15,
                                 1'b1), 1'b0, '0});

    // Configurations: extremes first (single site with zero hold, full group
    // with longest hold, id outside the group, count 0, count above the array)
    phase_cfg[0] = '{4'd0,  5'd1,  4'd0};
    phase_cfg[1] = '{4'd15, 5'd16, 4'd15};
    phase_cfg[2] = '{4'd3,  5'd4,  4'd1};
    phase_cfg[3] = '{4'd15, 5'd2,  4'd3};
    phase_cfg[4] = '{4'd0,  5'd0,  4'd2};
    phase_cfg[5] = '{4'd5,  5'd31, 4'd4};
    for (ph = 6; ph < NUM_PHASES; ph++) begin
      // mostly small groups keep the scan short
      phase_cfg[ph].count = ($urandom_range(0, 3) == 0) ? 5'd16 : 5'($urandom_range(2, 4));
      phase_cfg[ph].id    = 4'($urandom_range(0, int'(phase_cfg[ph].count) - 1));
      phase_cfg[ph].hold  = 4'($urandom_range(1, 6));
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    stall_en <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_tick(dir_rows[i].t, dir_rows[i].typed, dir_rows[i].want);

    // Random phases: mostly full request/grant/release rounds, some noise.
    // On each side, roughly a quarter of phases run with no idling.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      write_config(phase_cfg[ph]);
      src_idle = ($urandom_range(0, 3) != 0);
      stall_en <= ($urandom_range(0, 3) != 0);
      phases_run++;
      phase_ticks = 0;
      while (phase_ticks < PHASE_TICKS) begin
        if ($urandom_range(0, 9) < 7) begin
          run_session();
        end else begin
          repeat ($urandom_range(1, 4)) send_tick(rand_tick(), 1'b0, '0);
        end
      end
    end

    settle();
    $display("%0d ticks over %0d site configurations plus the directed walk", ticks_sent,
             phases_run);
    $display("%0d result items checked, %0d entries to the critical section", items_checked,
             cs_entries);
    if (fail_count == 0) begin
      $display("lamport_mutex_site regression: pass");
    end else begin
      $display("lamport_mutex_site regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5000000;
    $display("lamport_mutex_site regression: fail");
    $finish;
  end

endmodule
